// ===== rtl/kway_posting_list_intersect_defines.svh =====
// Assertion macros shared by the posting list intersection RTL.
// Depends on a clock named clk_i and an active-low reset named rst_ni in the including scope.
`ifndef KWAY_POSTING_LIST_INTERSECT_DEFINES_SVH
`define KWAY_POSTING_LIST_INTERSECT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define KPLI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define KPLI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/kpli_pkg.sv =====
// Shared types and constants for the posting list intersection block.
// No dependencies; imported by the top level.
`default_nettype none

package kpli_pkg;

  // Default sizes of the key store.
  localparam int DefMaxWords  = 8;
  localparam int DefFifoDepth = 16;
  localparam int DefKeyWidth  = 32;

  // Fixed field widths of the transfer payloads.
  localparam int SlotW   = 3;
  localparam int DocKeyW = 32;
  localparam int CfgW    = 4;

  // Reset value of the word count register.
  localparam logic [CfgW-1:0] CfgResetVal = CfgW'(1);

  // Matches produced per input item are capped at this count.
  localparam int ResultLimit = 16;
  localparam int EmitCntW    = $clog2(ResultLimit + 1);

  typedef struct packed {
    logic [SlotW-1:0]   word_slot;
    logic [DocKeyW-1:0] doc_key;
  } in_item_t;

  typedef struct packed {
    logic [DocKeyW-1:0] match_key;
    logic               last_of_run;
    logic               overflow_seen;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/kway_posting_list_intersect.sv =====
// After an input transfer, each merge round checks the heads and the match cap,
// scans the heads, one head read per cycle through the single RAM read port, then pops.
// A run closes with a final head check and a finish state that loads the last match.
// No new item is taken until the block is back in idle; output stalls hold up the merge.
// Reset clears pointers, counts, the overflow flag and sets words in use to 1.
// Key storage is not initialized; there is no clearing pass.
`default_nettype none
`include "kway_posting_list_intersect_defines.svh"

module kway_posting_list_intersect #(
  parameter int MAX_WORDS  = kpli_pkg::DefMaxWords,
  parameter int FIFO_DEPTH = kpli_pkg::DefFifoDepth,
  parameter int KEY_WIDTH  = kpli_pkg::DefKeyWidth
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [kpli_pkg::CfgW-1:0] cfg_wdata_i,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire kpli_pkg::in_item_t      in_data_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output kpli_pkg::out_item_t          out_data_o
);

  import kpli_pkg::*;

  localparam int WordW    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int WordCntW = $clog2(MAX_WORDS + 1);
  localparam int PtrW     = $clog2(FIFO_DEPTH);
  localparam int CntW     = $clog2(FIFO_DEPTH + 1);
  localparam int RamDepth = MAX_WORDS * FIFO_DEPTH;
  localparam int AddrW    = $clog2(RamDepth);

  // Sequencer state codes.
  localparam logic [2:0] StIdle     = 3'd0;
  localparam logic [2:0] StCheck    = 3'd1;
  localparam logic [2:0] StScan     = 3'd2;
  localparam logic [2:0] StScanLast = 3'd3;
  localparam logic [2:0] StPop      = 3'd4;
  localparam logic [2:0] StFinish   = 3'd5;

  logic [2:0]            state_q, state_d;
  logic [CfgW-1:0]       words_q;
  logic [WordCntW-1:0]   n_words;
  logic [PtrW-1:0]       rptr_q [MAX_WORDS];
  logic [PtrW-1:0]       rptr_d [MAX_WORDS];
  logic [PtrW-1:0]       wptr_q [MAX_WORDS];
  logic [PtrW-1:0]       wptr_d [MAX_WORDS];
  logic [CntW-1:0]       cnt_q  [MAX_WORDS];
  logic [CntW-1:0]       cnt_d  [MAX_WORDS];
  logic                  overflow_q, overflow_d;
  logic [WordW-1:0]      scan_idx_q, scan_idx_d;
  logic [WordW-1:0]      rd_idx_q, rd_idx_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [KEY_WIDTH-1:0]  min_q, min_d;
  logic [MAX_WORDS-1:0]  mask_q, mask_d;
  logic [KEY_WIDTH-1:0]  hold_q, hold_d;
  logic                  hold_vld_q, hold_vld_d;
  logic [EmitCntW-1:0]   emit_cnt_q, emit_cnt_d;
  logic                  out_vld_q, out_vld_d;
  out_item_t             out_q, out_d;

  logic [MAX_WORDS-1:0]  act_mask;
  logic [MAX_WORDS-1:0]  nonempty;
  logic                  heads_ready;
  logic                  in_xfer;
  logic                  slot_in_use;
  logic [WordW-1:0]      slot_idx;
  logic                  push_ok;
  logic                  ram_we;
  logic [AddrW-1:0]      ram_waddr;
  logic                  ram_re;
  logic [AddrW-1:0]      ram_raddr;
  logic [KEY_WIDTH-1:0]  ram_rdata;
  logic                  all_eq;
  logic                  out_busy;
  logic                  pop_go;
  logic [MAX_WORDS-1:0]  rd_onehot;

  // Effective word count: zero acts as one, large values clamp to MAX_WORDS.
  always_comb begin
    if (words_q == '0) begin
      n_words = WordCntW'(1);
    end else if (32'(words_q) > MAX_WORDS) begin
      n_words = WordCntW'(MAX_WORDS);
    end else begin
      n_words = WordCntW'(words_q);
    end
  end

  // Words in use and which of them have a pending head.
  always_comb begin
    for (int w = 0; w < MAX_WORDS; w++) begin
      act_mask[w] = (w < 32'(n_words));
      nonempty[w] = (cnt_q[w] != '0);
    end
  end
  assign heads_ready = &(~act_mask | nonempty);

  // Input transfer and queue write.
  assign in_stall_o  = (state_q != StIdle);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign slot_in_use = (32'(in_data_i.word_slot) < 32'(n_words));
  assign slot_idx    = WordW'(in_data_i.word_slot);
  assign push_ok     = (32'(cnt_q[slot_idx]) < FIFO_DEPTH);
  assign ram_we      = in_xfer && slot_in_use && push_ok;
  assign ram_waddr   = AddrW'(slot_idx) * AddrW'(FIFO_DEPTH) + AddrW'(wptr_q[slot_idx]);

  // Head read: one word per cycle during the scan.
  assign ram_re    = (state_q == StScan);
  assign ram_raddr = AddrW'(scan_idx_q) * AddrW'(FIFO_DEPTH) + AddrW'(rptr_q[scan_idx_q]);

  kpli_ram #(
    .Width (KEY_WIDTH),
    .Depth (RamDepth)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (KEY_WIDTH'(in_data_i.doc_key)),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_onehot = MAX_WORDS'(1) << rd_idx_q;
  assign all_eq    = (mask_q == act_mask);
  assign out_busy  = out_vld_q && out_stall_i;
  assign pop_go    = (state_q == StPop) && !(all_eq && hold_vld_q && out_busy);

  // Sequencer: scan heads for the minimum, pop matching heads, emit full matches.
  always_comb begin
    state_d    = state_q;
    scan_idx_d = scan_idx_q;
    rd_idx_d   = rd_idx_q;
    rd_vld_d   = 1'b0;
    min_d      = min_q;
    mask_d     = mask_q;
    hold_d     = hold_q;
    hold_vld_d = hold_vld_q;
    emit_cnt_d = emit_cnt_q;
    overflow_d = overflow_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && out_stall_i;
    for (int w = 0; w < MAX_WORDS; w++) begin
      rptr_d[w] = rptr_q[w];
      wptr_d[w] = wptr_q[w];
      cnt_d[w]  = cnt_q[w];
    end

    // Running minimum and the set of words whose head equals it.
    if (rd_vld_q) begin
      if (rd_idx_q == '0 || ram_rdata < min_q) begin
        min_d  = ram_rdata;
        mask_d = rd_onehot;
      end else if (ram_rdata == min_q) begin
        mask_d = mask_q | rd_onehot;
      end
    end

    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          emit_cnt_d = '0;
          if (slot_in_use) begin
            if (push_ok) begin
              wptr_d[slot_idx] = (32'(wptr_q[slot_idx]) == FIFO_DEPTH - 1) ? '0
                                 : wptr_q[slot_idx] + PtrW'(1);
              cnt_d[slot_idx]  = cnt_q[slot_idx] + CntW'(1);
            end else begin
              overflow_d = 1'b1;
            end
          end
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (32'(emit_cnt_q) == ResultLimit || !heads_ready) begin
          state_d = StFinish;
        end else begin
          scan_idx_d = '0;
          state_d    = StScan;
        end
      end
      StScan: begin
        rd_idx_d = scan_idx_q;
        rd_vld_d = 1'b1;
        if (32'(scan_idx_q) == 32'(n_words) - 1) begin
          state_d = StScanLast;
        end else begin
          scan_idx_d = scan_idx_q + WordW'(1);
        end
      end
      StScanLast: begin
        state_d = StPop;
      end
      StPop: begin
        if (pop_go) begin
          for (int w = 0; w < MAX_WORDS; w++) begin
            if (mask_q[w]) begin
              rptr_d[w] = (32'(rptr_q[w]) == FIFO_DEPTH - 1) ? '0 : rptr_q[w] + PtrW'(1);
              cnt_d[w]  = cnt_q[w] - CntW'(1);
            end
          end
          if (all_eq) begin
            // A newer match exists, so the held one is not the last of the run.
            if (hold_vld_q) begin
              out_d.match_key     = DocKeyW'(hold_q);
              out_d.last_of_run   = 1'b0;
              out_d.overflow_seen = overflow_q;
              out_vld_d           = 1'b1;
            end
            hold_d     = min_q;
            hold_vld_d = 1'b1;
            emit_cnt_d = emit_cnt_q + EmitCntW'(1);
          end
          state_d = StCheck;
        end
      end
      StFinish: begin
        if (!hold_vld_q) begin
          state_d = StIdle;
        end else if (!out_busy) begin
          out_d.match_key     = DocKeyW'(hold_q);
          out_d.last_of_run   = 1'b1;
          out_d.overflow_seen = overflow_q;
          out_vld_d           = 1'b1;
          hold_vld_d          = 1'b0;
          state_d             = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      words_q    <= CfgResetVal;
      overflow_q <= 1'b0;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      rd_vld_q   <= 1'b0;
      emit_cnt_q <= '0;
      scan_idx_q <= '0;
      rd_idx_q   <= '0;
      for (int w = 0; w < MAX_WORDS; w++) begin
        rptr_q[w] <= '0;
        wptr_q[w] <= '0;
        cnt_q[w]  <= '0;
      end
    end else begin
      state_q    <= state_d;
      overflow_q <= overflow_d;
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
      rd_vld_q   <= rd_vld_d;
      emit_cnt_q <= emit_cnt_d;
      scan_idx_q <= scan_idx_d;
      rd_idx_q   <= rd_idx_d;
      if (cfg_we_i) begin
        words_q <= cfg_wdata_i;
      end
      for (int w = 0; w < MAX_WORDS; w++) begin
        rptr_q[w] <= rptr_d[w];
        wptr_q[w] <= wptr_d[w];
        cnt_q[w]  <= cnt_d[w];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    min_q  <= min_d;
    mask_q <= mask_d;
    hold_q <= hold_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // The match count per item never passes the cap.
  `KPLI_ASSERT_NOW(a_emit_cap, 1'b1, 32'(emit_cnt_q) <= ResultLimit,
                   "match count exceeded the per-item cap")
  // Nothing is left held once the block is back to taking items.
  `KPLI_ASSERT_NOW(a_idle_no_hold, state_q == StIdle, !hold_vld_q,
                   "a held match survived into idle")
  // A pop always removes at least the minimum head.
  `KPLI_ASSERT_NOW(a_pop_nonempty, state_q == StPop, mask_q != '0,
                   "pop round with no head selected")
  // The overflow flag is sticky.
  `KPLI_ASSERT_NEXT(a_overflow_sticky, overflow_q, overflow_q,
                    "overflow flag was cleared")

endmodule

`default_nettype wire

// ===== rtl/kpli_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the per-word key queues.
`default_nettype none

module kpli_ram #(
  parameter int Width = 32,
  parameter int Depth = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== verif/kway_posting_list_intersect_tb.sv =====
// Self-checking testbench for the k-way posting list intersection block.
// Holds its own intersection predictor in a small scoreboard class and drives both channels.
// Depends on kpli_pkg and the kway_posting_list_intersect RTL.
`timescale 1ns / 1ps

module kway_posting_list_intersect_tb;
  import kpli_pkg::*;

  // Cycles the block may still spend merging after its last match.
  localparam int QuietCycles   = 1500;
  // Cycles without any transfer before the run is declared hung.
  localparam int WatchdogLimit = 20000;
  // Long output hold-off, started once after this many matches.
  localparam int HoldAfter     = 25;
  localparam int HoldCycles    = 300;
  localparam int RandomTarget  = 18;

  // Tracks the per-word key queues and the matches they must produce.
  class match_scoreboard;
    logic [CfgW-1:0]    word_count_reg;
    bit                 dropped_key;
    logic [DocKeyW-1:0] posting_q[DefMaxWords][$];
    out_item_t          expected_matches[$];
    int                 results_seen;
    int                 mismatches;

    function new();
      word_count_reg = CfgResetVal;
      dropped_key    = 1'b0;
      results_seen   = 0;
      mismatches     = 0;
    endfunction

    function void set_word_count(logic [CfgW-1:0] value);
      word_count_reg = value;
    endfunction

    // Zero counts as one word, anything above the maximum as the maximum.
    function int active_words();
      if (word_count_reg == 0) return 1;
      if (word_count_reg > DefMaxWords) return DefMaxWords;
      return int'(word_count_reg);
    endfunction

    function int pending();
      return expected_matches.size();
    endfunction

    // Queue the accepted key, then merge heads until a word runs dry or the cap is reached.
    function void note_key(in_item_t item);
      int                 n;
      int                 slot;
      bit                 ready;
      bit                 all_equal;
      logic [DocKeyW-1:0] low_key;
      out_item_t          hit;
      out_item_t          run[$];
      n    = active_words();
      slot = int'(item.word_slot);
      if (slot < n) begin
        if (posting_q[slot].size() >= DefFifoDepth) begin
          dropped_key = 1'b1;
        end else begin
          posting_q[slot].insert(posting_q[slot].size(), item.doc_key);
        end
      end
      while (run.size() < ResultLimit) begin
        ready = 1'b1;
        for (int w = 0; w < n; w++) if (posting_q[w].size() == 0) ready = 1'b0;
        if (!ready) break;
        low_key = posting_q[0][0];
        for (int w = 1; w < n; w++) if (posting_q[w][0] < low_key) low_key = posting_q[w][0];
        all_equal = 1'b1;
        for (int w = 0; w < n; w++) if (posting_q[w][0] != low_key) all_equal = 1'b0;
        if (all_equal) begin
          hit.match_key     = low_key;
          hit.last_of_run   = 1'b0;
          hit.overflow_seen = 1'b0;
          run.insert(run.size(), hit);
        end
        for (int w = 0; w < n; w++) begin
          if (posting_q[w][0] == low_key) posting_q[w].delete(0);
        end
      end
      // The overflow flag is taken after the drop decision; the final match closes the run.
      foreach (run[k]) begin
        run[k].overflow_seen = dropped_key;
        run[k].last_of_run   = (k == run.size() - 1);
        expected_matches.insert(expected_matches.size(), run[k]);
      end
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    // Compare one output transfer with the oldest expected match.
    task check_match(out_item_t got);
      out_item_t want;
      results_seen++;
      if (expected_matches.size() == 0) begin
        report_mismatch($sformatf("unexpected match, key %h", got.match_key));
        return;
      end
      want = expected_matches[0];
      expected_matches.delete(0);
      if (got.match_key !== want.match_key)
        report_mismatch($sformatf("match_key %h, expected %h", got.match_key, want.match_key));
      if (got.last_of_run !== want.last_of_run)
        report_mismatch($sformatf("last_of_run %b, expected %b (key %h)",
                                  got.last_of_run, want.last_of_run, want.match_key));
      if (got.overflow_seen !== want.overflow_seen)
        report_mismatch($sformatf("overflow_seen %b, expected %b (key %h)",
                                  got.overflow_seen, want.overflow_seen, want.match_key));
    endtask
  endclass

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            cfg_we_i    = 1'b0;
  logic [CfgW-1:0] cfg_wdata_i = CfgResetVal;
  logic            in_valid_i  = 1'b0;
  in_item_t        in_data_i   = '0;
  logic            out_stall_i = 1'b0;
  logic            in_stall_o;
  logic            out_valid_o;
  out_item_t       out_data_o;

  match_scoreboard sb = new();
  bit              steady = 1'b0;
  int              idle_cycles = 0;

  kway_posting_list_intersect dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_length();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Both channels are observed at the clock edge, before any driver update lands.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_key(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_match(out_data_o);
    end
  end

  // Hang detection: count cycles in which no transfer happens on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Output side: random stalls, plus one long hold-off so the block backs up.
  initial begin : receiver
    int  stall_left;
    bit  held;
    stall_left = 0;
    held       = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && sb.results_seen >= HoldAfter) begin
        held       = 1'b1;
        stall_left = HoldCycles;
      end else if (stall_left == 0 && !steady && $urandom_range(0, 3) == 0) begin
        stall_left = gap_length();
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offer one key and hold it until the transfer, then maybe leave a gap.
  task automatic send_key(input logic [SlotW-1:0] slot, input logic [DocKeyW-1:0] key);
    in_item_t item;
    int       gap;
    item.word_slot = slot;
    item.doc_key   = key;
    in_data_i  <= item;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    gap = (!steady && $urandom_range(0, 9) < 4) ? gap_length() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop offering, collect every expected match, then let a merge in progress finish.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (QuietCycles) @(posedge clk_i);
  endtask

  task automatic write_word_count(input logic [CfgW-1:0] value);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_word_count(value);
  endtask

  // Ascending lists with shared keys, spread over the words in use and interleaved at
  // random; a few stray keys land on any slot, in or out of order.
  task automatic random_phase(input logic [CfgW-1:0] setting, input int target);
    int                 n;
    int                 sent;
    int                 w;
    bit                 common;
    bit                 any_left;
    logic [SlotW-1:0]   slot;
    logic [DocKeyW-1:0] key;
    logic [DocKeyW-1:0] next_key;
    logic [DocKeyW-1:0] lists[DefMaxWords][$];
    settle();
    write_word_count(setting);
    steady   = ($urandom_range(0, 3) == 0);
    n        = sb.active_words();
    next_key = $urandom_range(0, 32'hFFFF_0000);
    sent     = 0;
    while (sent < target) begin
      if ($urandom_range(0, 9) == 0) begin
        slot = SlotW'($urandom_range(0, 7));
        key  = $urandom_range(0, 1) ? $urandom : next_key + $urandom_range(0, 8);
        send_key(slot, key);
        if (slot < n) sent++;
      end else begin
        for (int k = 0; k < 4; k++) begin
          next_key += $urandom_range(1, 3);
          common = ($urandom_range(0, 1) == 1);
          for (int s = 0; s < n; s++) begin
            if (common || $urandom_range(0, 1)) lists[s].insert(lists[s].size(), next_key);
          end
        end
        forever begin
          any_left = 1'b0;
          for (int s = 0; s < n; s++) if (lists[s].size() != 0) any_left = 1'b1;
          if (!any_left) break;
          do w = $urandom_range(0, n - 1); while (lists[w].size() == 0);
          key = lists[w][0];
          lists[w].delete(0);
          send_key(SlotW'(w), key);
          sent++;
        end
      end
    end
  endtask

  // Reset, directed cases, random phases over several word counts, then the verdict.
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A count of zero acts as one word: every queued key matches at once.
    write_word_count(4'd0);
    send_key(3'd0, 32'h0000_0000);
    send_key(3'd0, 32'hFFFF_FFFF);
    // Slots beyond the words in use are ignored.
    send_key(3'd7, 32'h0000_0005);
    send_key(3'd1, 32'h0000_0003);

    // Two words, only the first fed: it fills up and the extra key is dropped.
    settle();
    write_word_count(4'd2);
    for (int i = 0; i <= DefFifoDepth; i++) begin
      send_key(3'd0, (i == DefFifoDepth) ? 32'hFFFF_FFFF : i * 32'h0F0F_0F0F);
    end

    // Back to one word: the queue is kept, and an ignored key releases a full run.
    settle();
    write_word_count(4'd1);
    send_key(3'd7, 32'hDEAD_BEEF);

    random_phase(4'd1, RandomTarget);
    random_phase(4'd3, RandomTarget);
    random_phase(4'd8, RandomTarget);
    random_phase(4'd0, RandomTarget);
    random_phase(4'd15, RandomTarget);
    random_phase(4'd5, RandomTarget);
    random_phase(4'd2, RandomTarget);

    settle();
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
